// ----- design/lcw_pkg.sv -----
// Shared types and constants for the load-cell tare, calibration and weighing block.
// Used by the divider, the core and the testbench; depends on nothing else.
package lcw_pkg;

    localparam int WEIGHT_BITS = 32;
    localparam int HUNDRED = 100;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_TARE = 2'd1,
        CMD_ZERO = 2'd2,
        CMD_LOAD = 2'd3
    } lcw_cmd_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_POINT_LOAD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPAN_POINT_LOAD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_LOAD_SPAN = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_ADC_SPAN = 2'd3;

    localparam int RST_ZERO_POINT_LOAD = 0;
    localparam int RST_SPAN_POINT_LOAD = 255;
    localparam int RST_START_LOAD_SPAN = 1000;
    localparam int RST_START_ADC_SPAN = 1560;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic overflow;
        logic [WEIGHT_BITS-1:0] quot;
    } lcw_quot_t;

endpackage

// ----- design/lcw_serial_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on nothing beyond its parameters.
module lcw_serial_mul #(
    parameter int A_BITS = 24,
    parameter int B_BITS = 23
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [A_BITS-1:0]        a,
    input  logic [B_BITS-1:0]        b,
    output logic [A_BITS+B_BITS-1:0] prod,
    output logic                     done
);
    localparam int P_BITS = A_BITS + B_BITS;
    localparam int CNT_BITS = $clog2(A_BITS + 1);

    logic [A_BITS-1:0] a_reg;
    logic [B_BITS-1:0] b_reg;
    logic [P_BITS-1:0] prod_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [P_BITS-1:0] addend;

    assign addend = a_reg[A_BITS-1] ? P_BITS'(b_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(A_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= {prod_reg[P_BITS-2:0], 1'b0} + addend;
            a_reg <= {a_reg[A_BITS-2:0], 1'b0};
        end
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

// ----- design/lcw_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, with a sticky flag for quotient
// bits above the weight width. Depends on lcw_pkg.
module lcw_serial_div #(
    parameter int N_BITS = 47,
    parameter int D_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [N_BITS-1:0] dividend,
    input  logic [D_BITS-1:0] divisor,
    output lcw_pkg::lcw_quot_t result,
    output logic              done
);
    import lcw_pkg::*;

    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic [N_BITS-1:0] dvd_reg;
    logic [D_BITS-1:0] dsr_reg;
    logic [D_BITS-1:0] rem_reg;
    logic [WEIGHT_BITS-1:0] quot_reg;
    logic ovf_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [D_BITS:0] trial;
    logic [D_BITS:0] diff;
    logic fits;

    assign trial = {rem_reg, dvd_reg[N_BITS-1]};
    assign diff = trial - {1'b0, dsr_reg};
    assign fits = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(N_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quot_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[N_BITS-2:0], 1'b0};
            rem_reg <= fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
            quot_reg <= {quot_reg[WEIGHT_BITS-2:0], fits};
            ovf_reg <= ovf_reg | quot_reg[WEIGHT_BITS-1];
        end
    end

    assign result.overflow = ovf_reg;
    assign result.quot = quot_reg;
    assign done = done_reg;

endmodule

// ----- design/load_cell_tare_calibrate_weigh_core.sv -----
// Load-cell tare, two-point calibration and weighing core.
// Each item passes through the bit-serial multiply and then the restoring divide; the
// next item is accepted only after the result has been moved to the output registers.
// The result is valid in the same cycle that the next item can be accepted; a waiting result
// does not block acceptance of the next item. Reset is asynchronous, active low, and
// restores the start scale, zero tare and calibration samples, and the default loads.
module load_cell_tare_calibrate_weigh_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int LOAD_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [lcw_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [(SAMPLE_BITS > LOAD_BITS ? SAMPLE_BITS : LOAD_BITS)-1:0] cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              cmd,
    input  logic [SAMPLE_BITS-1:0]                  sample,
    input  logic                                    timed_out,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [lcw_pkg::WEIGHT_BITS-1:0]  weight,
    output logic [SAMPLE_BITS-1:0]                  raw_value,
    output logic                                    cal_rejected
);
    import lcw_pkg::*;

    localparam int NUM_BITS = LOAD_BITS + 7;
    localparam int PROD_BITS = SAMPLE_BITS + NUM_BITS;
    localparam int CMP_BITS = SAMPLE_BITS > NUM_BITS ? SAMPLE_BITS : NUM_BITS;
    localparam logic [LOAD_BITS-1:0] RST_LOAD = LOAD_BITS'(RST_START_LOAD_SPAN);
    localparam logic [SAMPLE_BITS-1:0] RST_ADC = SAMPLE_BITS'(RST_START_ADC_SPAN);
    localparam logic RST_SCALED =
        CMP_BITS'(RST_ADC) > CMP_BITS'(NUM_BITS'(RST_LOAD) * NUM_BITS'(HUNDRED));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [LOAD_BITS-1:0] zero_point_load_reg;
    logic [LOAD_BITS-1:0] span_point_load_reg;
    logic [LOAD_BITS-1:0] start_load_span_reg;
    logic [SAMPLE_BITS-1:0] start_adc_span_reg;
    logic [SAMPLE_BITS-1:0] tare_offset_reg;
    logic [SAMPLE_BITS-1:0] zero_point_sample_reg;
    logic [SAMPLE_BITS-1:0] load_point_sample_reg;
    logic [LOAD_BITS-1:0] load_span_reg;
    logic [SAMPLE_BITS-1:0] adc_span_reg;
    logic scaled_reg;
    logic calibrated_reg;

    logic [SAMPLE_BITS-1:0] raw_reg;
    logic rejected_reg;
    logic neg_reg;
    logic mul_start_reg;

    logic out_valid_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [SAMPLE_BITS-1:0] raw_value_reg;
    logic cal_rejected_reg;

    logic in_accept;
    logic [SAMPLE_BITS-1:0] raw_in;
    logic [LOAD_BITS-1:0] dl;
    logic [SAMPLE_BITS-1:0] da;
    logic cal_ok;
    logic cal_scaled;
    logic [LOAD_BITS-1:0] cfg_load_next;
    logic [SAMPLE_BITS-1:0] cfg_adc_next;
    logic cfg_scaled_next;
    logic cfg_reload;

    logic neg_now;
    logic [SAMPLE_BITS-1:0] mag;
    logic [NUM_BITS-1:0] num;
    logic [PROD_BITS-1:0] prod;
    logic mul_done;
    lcw_quot_t div_result;
    logic div_done;
    logic sat;
    logic [WEIGHT_BITS-1:0] q_final;
    logic [WEIGHT_BITS-1:0] weight_next;
    logic out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    assign raw_in = timed_out ? '0 : {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};
    assign dl = (span_point_load_reg > zero_point_load_reg)
        ? span_point_load_reg - zero_point_load_reg
        : zero_point_load_reg - span_point_load_reg;
    assign da = (zero_point_sample_reg > raw_in)
        ? zero_point_sample_reg - raw_in
        : raw_in - zero_point_sample_reg;
    assign cal_ok = (dl != '0) && (da != '0);
    assign cal_scaled = CMP_BITS'(da) > CMP_BITS'(NUM_BITS'(dl) * NUM_BITS'(HUNDRED));

    assign cfg_load_next = (cfg_index == CFG_START_LOAD_SPAN)
        ? cfg_data[LOAD_BITS-1:0] : start_load_span_reg;
    assign cfg_adc_next = (cfg_index == CFG_START_ADC_SPAN)
        ? cfg_data[SAMPLE_BITS-1:0] : start_adc_span_reg;
    assign cfg_scaled_next =
        CMP_BITS'(cfg_adc_next) > CMP_BITS'(NUM_BITS'(cfg_load_next) * NUM_BITS'(HUNDRED));
    assign cfg_reload = cfg_we && !calibrated_reg
        && (cfg_index == CFG_START_LOAD_SPAN || cfg_index == CFG_START_ADC_SPAN);

    assign neg_now = tare_offset_reg < raw_reg;
    assign mag = neg_now ? raw_reg - tare_offset_reg : tare_offset_reg - raw_reg;
    assign num = scaled_reg ? NUM_BITS'(load_span_reg) * NUM_BITS'(HUNDRED)
                            : NUM_BITS'(load_span_reg);

    lcw_serial_mul #(
        .A_BITS(SAMPLE_BITS),
        .B_BITS(NUM_BITS)
    ) u_mul (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_start_reg),
        .a(mag),
        .b(num),
        .prod(prod),
        .done(mul_done)
    );

    lcw_serial_div #(
        .N_BITS(PROD_BITS),
        .D_BITS(SAMPLE_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_done),
        .dividend(prod),
        .divisor(adc_span_reg),
        .result(div_result),
        .done(div_done)
    );

    always_comb
    begin
        if (neg_reg)
        begin
            sat = div_result.overflow || (div_result.quot > WEIGHT_NEG_LIMIT);
            q_final = sat ? WEIGHT_NEG_LIMIT : div_result.quot;
            q_final = '0 - q_final;
        end
        else
        begin
            sat = div_result.overflow || div_result.quot[WEIGHT_BITS-1];
            q_final = sat ? WEIGHT_POS_LIMIT : div_result.quot;
        end
        weight_next = (adc_span_reg == '0) ? '0 : q_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            zero_point_load_reg <= LOAD_BITS'(RST_ZERO_POINT_LOAD);
            span_point_load_reg <= LOAD_BITS'(RST_SPAN_POINT_LOAD);
            start_load_span_reg <= RST_LOAD;
            start_adc_span_reg <= RST_ADC;
            tare_offset_reg <= '0;
            zero_point_sample_reg <= '0;
            load_point_sample_reg <= '0;
            load_span_reg <= RST_LOAD;
            adc_span_reg <= RST_ADC;
            scaled_reg <= RST_SCALED;
            calibrated_reg <= 1'b0;
            raw_reg <= '0;
            rejected_reg <= 1'b0;
            neg_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            weight_reg <= '0;
            raw_value_reg <= '0;
            cal_rejected_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= in_accept;
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ZERO_POINT_LOAD: zero_point_load_reg <= cfg_data[LOAD_BITS-1:0];
                    CFG_SPAN_POINT_LOAD: span_point_load_reg <= cfg_data[LOAD_BITS-1:0];
                    CFG_START_LOAD_SPAN: start_load_span_reg <= cfg_data[LOAD_BITS-1:0];
                    CFG_START_ADC_SPAN: start_adc_span_reg <= cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
                if (cfg_reload)
                begin
                    load_span_reg <= cfg_load_next;
                    adc_span_reg <= cfg_adc_next;
                    scaled_reg <= cfg_scaled_next;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        raw_reg <= raw_in;
                        rejected_reg <= 1'b0;
                        state_reg <= ST_MUL;
                        unique case (lcw_cmd_t'(cmd))
                            CMD_MEASURE: ;
                            CMD_TARE: tare_offset_reg <= raw_in;
                            CMD_ZERO: zero_point_sample_reg <= raw_in;
                            CMD_LOAD:
                            begin
                                load_point_sample_reg <= raw_in;
                                if (cal_ok)
                                begin
                                    load_span_reg <= dl;
                                    adc_span_reg <= da;
                                    scaled_reg <= cal_scaled;
                                    calibrated_reg <= 1'b1;
                                end
                                else
                                begin
                                    rejected_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    if (mul_start_reg)
                    begin
                        neg_reg <= neg_now;
                    end
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        weight_reg <= weight_next;
                        raw_value_reg <= raw_reg;
                        cal_rejected_reg <= rejected_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign weight = weight_reg;
    assign raw_value = raw_value_reg;
    assign cal_rejected = cal_rejected_reg;

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside the multiply phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> mul_start_reg)
        else $error("accepted item did not start the multiplier");

    a_calibrated_by_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(calibrated_reg) |-> $past(in_accept && cmd == CMD_LOAD))
        else $error("calibration flag set without a load capture");

    a_rejected_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd != CMD_LOAD) |=> !rejected_reg)
        else $error("rejection flagged for a command other than load capture");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for load_cell_tare_calibrate_weigh_core.
// Drives weigh, tare and calibration items, predicts each weight in-line and checks every result.
// Depends only on lcw_pkg and the core itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcw_pkg::*;

    localparam int HOLD_CYCLES = 3000;
    localparam int QUIET_LIMIT = 10000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        lcw_cmd_t    op;
        logic [23:0] smp;
        logic        tmo;
    } weigh_item_t;

    typedef struct {
        logic [31:0] weight;
        logic [23:0] raw;
        logic        rej;
    } weigh_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_ZERO_POINT_LOAD;
    logic [23:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             cmd = CMD_MEASURE;
    logic [23:0]            sample = '0;
    logic                   timed_out = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [31:0]     weight;
    logic [23:0]            raw_value;
    logic                   cal_rejected;

    load_cell_tare_calibrate_weigh_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .sample      (sample),
        .timed_out   (timed_out),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .weight      (weight),
        .raw_value   (raw_value),
        .cal_rejected(cal_rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the block's registers and calibration state.
    logic [15:0] zp_load;
    logic [15:0] sp_load;
    logic [15:0] st_load_span;
    logic [23:0] st_adc_span;
    logic [23:0] tare;
    logic [23:0] zero_smp;
    logic [15:0] lspan;
    logic [23:0] aspan;
    bit          by100;
    bit          cal_done;

    weigh_item_t   readings[$];
    weigh_result_t due_weights[$];

    int  n_queued = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_err = 0;
    int  n_rej = 0;
    int  n_sat = 0;
    int  n_cal = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_taken = 1'b0;
    int  quiet = 0;

    function automatic void reload_start_scale();
        lspan = st_load_span;
        aspan = st_adc_span;
        by100 = 64'(aspan) > 64'(lspan) * 64'd100;
    endfunction

    function automatic logic [31:0] scaled_weight(logic [23:0] raw);
        bit neg;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned lim;
        longint unsigned q;
        neg = tare < raw;
        mag = neg ? 64'(raw) - 64'(tare) : 64'(tare) - 64'(raw);
        num = 64'(lspan) * (by100 ? 64'd100 : 64'd1);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (aspan == 0 || mag == 0 || num == 0)
            return '0;
        q = (mag * num) / 64'(aspan);
        if (q > lim)
        begin
            q = lim;
            n_sat++;
        end
        return neg ? 32'(0) - q[31:0] : q[31:0];
    endfunction

    function automatic weigh_result_t weigh_step(lcw_cmd_t op, logic [23:0] smp, logic tmo);
        weigh_result_t r;
        logic [23:0] raw;
        logic [15:0] dl;
        logic [23:0] da;
        raw = tmo ? 24'd0 : {~smp[23], smp[22:0]};
        r.rej = 1'b0;
        case (op)
            CMD_TARE: tare = raw;
            CMD_ZERO: zero_smp = raw;
            CMD_LOAD:
            begin
                dl = (sp_load > zp_load) ? sp_load - zp_load : zp_load - sp_load;
                da = (zero_smp > raw) ? zero_smp - raw : raw - zero_smp;
                if (dl == 0 || da == 0)
                begin
                    r.rej = 1'b1;
                    n_rej++;
                end
                else
                begin
                    lspan = dl;
                    aspan = da;
                    by100 = 64'(da) > 64'(dl) * 64'd100;
                    cal_done = 1'b1;
                    n_cal++;
                end
            end
            default: ;
        endcase
        r.weight = scaled_weight(raw);
        r.raw = raw;
        return r;
    endfunction

    // Sender: presents queued items and records the predicted result on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        weigh_item_t nxt;
        logic v;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_MEASURE;
            sample <= '0;
            timed_out <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            v = in_valid;
            if (in_valid && !in_stall)
            begin
                due_weights.push_back(weigh_step(lcw_cmd_t'(cmd), sample, timed_out));
                n_in++;
                v = 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 14);
            end
            if (!v)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (readings.size() > 0)
                begin
                    nxt = readings.pop_front();
                    cmd <= nxt.op;
                    sample <= nxt.smp;
                    timed_out <= nxt.tmo;
                    v = 1'b1;
                end
            end
            in_valid <= v;
        end
    end

    // Receiver: checks each accepted result and stalls in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        weigh_result_t want;
        logic st;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_out++;
                if (due_weights.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: result with nothing expected: weight %0d raw %06h rej %0b",
                                 $realtime, weight, raw_value, cal_rejected);
                end
                else
                begin
                    want = due_weights.pop_front();
                    if (weight !== want.weight || raw_value !== want.raw
                        || cal_rejected !== want.rej)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"%0t: result %0d mismatch: expected weight %0d raw %06h ",
                                      "rej %0b, got weight %0d raw %06h rej %0b"},
                                     $realtime, n_out, $signed(want.weight), want.raw, want.rej,
                                     weight, raw_value, cal_rejected);
                    end
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                st = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                st = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 14) - 1;
                st = 1'b1;
            end
            else
                st = 1'b0;
            out_stall <= st;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("No item moved for %0d cycles.", QUIET_LIMIT);
                $display("** load_cell_tare_calibrate_weigh_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic add_reading(input lcw_cmd_t op, input logic [23:0] smp, input logic tmo);
        weigh_item_t it;
        it.op = op;
        it.smp = smp;
        it.tmo = tmo;
        readings.push_back(it);
        n_queued++;
    endtask

    function automatic logic [23:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly calibration runs (zero capture, nearby or distant load capture, a few weighs),
    // the rest single items with any command.
    task automatic add_random_readings(input int n);
        int target;
        logic [23:0] s;
        target = n_queued + n;
        while (n_queued < target)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                s = rand_word();
                if ($urandom_range(0, 3) == 0)
                    add_reading(CMD_TARE, rand_word(), 1'b0);
                add_reading(CMD_ZERO, s, 1'b0);
                add_reading(CMD_LOAD, s + (($urandom_range(0, 3) == 0) ? 24'($urandom)
                                           : 24'($urandom_range(0, 40))), 1'b0);
                repeat ($urandom_range(1, 4))
                    add_reading(CMD_MEASURE, rand_word(), 1'b0);
            end
            else
                add_reading(lcw_cmd_t'($urandom_range(0, 3)), rand_word(),
                            $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ZERO_POINT_LOAD: zp_load = val[15:0];
            CFG_SPAN_POINT_LOAD: sp_load = val[15:0];
            CFG_START_LOAD_SPAN: st_load_span = val[15:0];
            CFG_START_ADC_SPAN: st_adc_span = val;
            default: ;
        endcase
        if ((idx == CFG_START_LOAD_SPAN || idx == CFG_START_ADC_SPAN) && !cal_done)
            reload_start_scale();
    endtask

    task automatic wait_drained();
        while (n_out < n_queued)
            @(posedge clk);
    endtask

    initial
    begin
        zp_load = 16'(RST_ZERO_POINT_LOAD);
        sp_load = 16'(RST_SPAN_POINT_LOAD);
        st_load_span = 16'(RST_START_LOAD_SPAN);
        st_adc_span = 24'(RST_START_ADC_SPAN);
        tare = '0;
        zero_smp = '0;
        cal_done = 1'b0;
        reload_start_scale();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset scale: sign and timeout handling, tare, and rejected load captures.
        add_reading(CMD_MEASURE, 24'h000000, 1'b0);
        add_reading(CMD_MEASURE, 24'h800000, 1'b0);
        add_reading(CMD_MEASURE, 24'h7FFFFF, 1'b0);
        add_reading(CMD_MEASURE, 24'hFFFFFF, 1'b1);
        add_reading(CMD_TARE, 24'h123456, 1'b0);
        add_reading(CMD_MEASURE, 24'h000000, 1'b0);
        add_reading(CMD_MEASURE, 24'hFFFFFF, 1'b0);
        add_reading(CMD_TARE, 24'hABCDEF, 1'b1);
        add_reading(CMD_ZERO, 24'h7FFFFF, 1'b0);
        add_reading(CMD_LOAD, 24'h7FFFFF, 1'b0);
        add_reading(CMD_ZERO, 24'h5A5A5A, 1'b1);
        add_reading(CMD_LOAD, 24'hA5A5A5, 1'b1);
        wait_drained();

        // Uncalibrated: equal loads reject every load capture, start spans set the scale.
        set_reg(CFG_ZERO_POINT_LOAD, 24'hFFFF);
        set_reg(CFG_SPAN_POINT_LOAD, 24'hFFFF);
        set_reg(CFG_START_LOAD_SPAN, 24'hFFFF);
        set_reg(CFG_START_ADC_SPAN, 24'd1);
        add_random_readings(110);
        wait_drained();
        set_reg(CFG_START_LOAD_SPAN, 24'd1);
        set_reg(CFG_START_ADC_SPAN, 24'hFFFFFF);
        add_random_readings(110);
        wait_drained();
        set_reg(CFG_ZERO_POINT_LOAD, 24'd0);
        set_reg(CFG_SPAN_POINT_LOAD, 24'd0);
        set_reg(CFG_START_LOAD_SPAN, 24'd1000);
        set_reg(CFG_START_ADC_SPAN, 24'd0);
        add_reading(CMD_MEASURE, 24'h7FFFFF, 1'b0);
        add_random_readings(110);
        wait_drained();

        // First accepted calibration, including a one-count ADC span.
        set_reg(CFG_START_ADC_SPAN, 24'd1560);
        set_reg(CFG_SPAN_POINT_LOAD, 24'hFFFF);
        add_reading(CMD_TARE, 24'h000000, 1'b0);
        add_reading(CMD_ZERO, 24'h000000, 1'b0);
        add_reading(CMD_LOAD, 24'h000001, 1'b0);
        add_reading(CMD_MEASURE, 24'h7FFFFF, 1'b0);
        add_reading(CMD_MEASURE, 24'h800000, 1'b0);
        add_reading(CMD_ZERO, 24'h800000, 1'b0);
        add_reading(CMD_LOAD, 24'h7FFFFF, 1'b0);
        add_reading(CMD_MEASURE, 24'h000000, 1'b1);
        add_random_readings(250);
        wait_drained();

        // Start spans are now frozen; reversed loads; the output side holds off for a long time.
        set_reg(CFG_START_LOAD_SPAN, 24'd3);
        set_reg(CFG_START_ADC_SPAN, 24'd7);
        set_reg(CFG_ZERO_POINT_LOAD, 24'hFFFF);
        set_reg(CFG_SPAN_POINT_LOAD, 24'd0);
        add_random_readings(250);
        hold_req = 1'b1;
        wait_drained();

        set_reg(CFG_ZERO_POINT_LOAD, 24'd7);
        set_reg(CFG_SPAN_POINT_LOAD, 24'd7);
        add_random_readings(150);
        wait_drained();

        set_reg(CFG_ZERO_POINT_LOAD, 24'($urandom_range(0, 1000)));
        set_reg(CFG_SPAN_POINT_LOAD, 24'($urandom_range(0, 65535)));
        add_random_readings(150);
        wait_drained();
        calm = 1'b1;
        add_random_readings(200);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d items: %0d calibrations taken, %0d captures rejected.",
                 n_out, n_in, n_cal, n_rej);
        $display("%0d weights saturated; %0d mismatches.", n_sat, n_err);
        if (n_err == 0 && due_weights.size() == 0)
            $display("** load_cell_tare_calibrate_weigh_core: PASSED **");
        else
            $display("** load_cell_tare_calibrate_weigh_core: FAILED **");
        $finish;
    end

endmodule
